[hw/rtl/dq_pkg.sv]
// Package for the double-ended queue: operation codes, error codes and
// the command and status structs between controller and datapath.
// No dependencies.
package dq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

[hw/rtl/dq_if.sv]
// Valid/ready channel interfaces for the double-ended queue: the operation
// channel and the result channel. Depends on nothing.
interface dq_op_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  opcode;
    logic signed [31:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic        [4:0]  element_count;
    logic               is_empty;
    logic               is_full;
    logic        [1:0]  error_code;

    modport source (output valid, output front_value, output back_value,
                    output element_count, output is_empty, output is_full,
                    output error_code, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input element_count, input is_empty, input is_full,
                    input error_code, output ready);
endinterface

[hw/rtl/double_ended_queue.sv]
// Each transaction passes through these steps in order: the accepting cycle
// captures it, then come the pointer and store update, a registered read of
// both ends of the store, and the load of the result register. A new
// transaction is not taken before the last one is through its load. The next
// transaction is taken in the cycle after the load, while the result may still
// wait to be taken; a stalled result register holds the sequence in its load
// step. The store of DEPTH entries has one write port and two read ports, one
// per end.
//
// Top level of the double-ended queue; instantiates dq_ctrl and dq_dpath.
// Depends on dq_pkg and the channel interfaces in dq_if.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_op_if.sink    i_cmd,
    dq_rsp_if.source o_rsp
);

    dq_pkg::t_cmd  w_cmd;
    dq_pkg::t_stat w_stat;
    logic          w_ready;

    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (w_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    dq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_opcode        (i_cmd.opcode),
        .i_push_value    (i_cmd.push_value),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_front_value   (o_rsp.front_value),
        .o_back_value    (o_rsp.back_value),
        .o_element_count (o_rsp.element_count),
        .o_is_empty      (o_rsp.is_empty),
        .o_is_full       (o_rsp.is_full),
        .o_error_code    (o_rsp.error_code)
    );

    assign i_cmd.ready = w_ready;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("new transaction accepted while one is in progress");

    a_empty_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.is_empty |->
            o_rsp.front_value == dq_pkg::EMPTY_VALUE &&
            o_rsp.back_value == dq_pkg::EMPTY_VALUE)
        else $error("empty queue result does not read as minus one");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.error_code == dq_pkg::ERR_OVERFLOW |->
            o_rsp.is_full && !o_rsp.is_empty)
        else $error("overflow reported on a queue that is not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.error_code == dq_pkg::ERR_UNDERFLOW |->
            o_rsp.is_empty && !o_rsp.is_full)
        else $error("underflow reported on a queue that is not empty");

endmodule

[hw/rtl/dq_ctrl.sv]
// Controller of the double-ended queue: sequences capture, update, memory
// read and result load for one transaction at a time. Uses dq_pkg.
module dq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dq_pkg::t_stat i_stat,
    output dq_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.read    = (r_state == S_READ);
    assign o_cmd.load    = (r_state == S_LOAD) && i_stat.out_free;

endmodule

[hw/rtl/dq_dpath.sv]
// Datapath of the double-ended queue: circular store, head and tail
// pointers, fill count and the result register. Uses dq_pkg.
module dq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dq_pkg::t_cmd       i_cmd,
    output dq_pkg::t_stat      o_stat,
    input  logic        [2:0]  i_opcode,
    input  logic signed [31:0] i_push_value,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_front_value,
    output logic signed [31:0] o_back_value,
    output logic        [4:0]  o_element_count,
    output logic               o_is_empty,
    output logic               o_is_full,
    output logic        [1:0]  o_error_code
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] f_dec(input logic [IW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - IW'(1);
    endfunction

    logic signed [31:0] r_mem [DEPTH];
    logic        [2:0]  r_op;
    logic signed [31:0] r_val;
    logic [IW-1:0]      r_head;
    logic [IW-1:0]      r_tail;
    logic [CW-1:0]      r_count;
    logic [1:0]         r_err;
    logic signed [31:0] r_rd_front;
    logic signed [31:0] r_rd_back;
    logic               r_out_valid;

    logic [IW-1:0] n_head;
    logic [IW-1:0] n_tail;
    logic [CW-1:0] n_count;
    logic [1:0]    n_err;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic          w_full;
    logic          w_empty;
    logic [CW+4:0] w_cnt_ext;

    assign w_full  = (r_count == FULL_CNT);
    assign w_empty = (r_count == '0);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_err   = dq_pkg::ERR_NONE;
        w_we    = 1'b0;
        w_waddr = r_tail;
        case (r_op)
            dq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_err = dq_pkg::ERR_OVERFLOW;
                end else begin
                    n_head  = f_dec(r_head);
                    w_waddr = f_dec(r_head);
                    w_we    = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::OP_PUSH_REAR: begin
                if (w_full) begin
                    n_err = dq_pkg::ERR_OVERFLOW;
                end else begin
                    w_we    = 1'b1;
                    n_tail  = f_inc(r_tail);
                    n_count = r_count + CW'(1);
                end
            end
            dq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    n_err = dq_pkg::ERR_UNDERFLOW;
                end else begin
                    n_head  = f_inc(r_head);
                    n_count = r_count - CW'(1);
                end
            end
            dq_pkg::OP_POP_REAR: begin
                if (w_empty) begin
                    n_err = dq_pkg::ERR_UNDERFLOW;
                end else begin
                    n_tail  = f_dec(r_tail);
                    n_count = r_count - CW'(1);
                end
            end
            dq_pkg::OP_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_waddr] <= r_val;
        end
        if (i_cmd.read) begin
            r_rd_front <= r_mem[r_head];
            r_rd_back  <= r_mem[f_dec(r_tail)];
        end
    end

    assign w_cnt_ext = {5'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_front_value   <= w_empty ? dq_pkg::EMPTY_VALUE : r_rd_front;
            o_back_value    <= w_empty ? dq_pkg::EMPTY_VALUE : r_rd_back;
            o_element_count <= w_cnt_ext[4:0];
            o_is_empty      <= w_empty;
            o_is_full       <= w_full;
            o_error_code    <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

[test/double_ended_queue_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: random and directed deque commands,
// each result checked against an in-bench mirror of the queue contents.
// Depends on dq_pkg and the channel interfaces in dq_if.
module double_ended_queue_test;

    localparam int DEPTH = 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_TAIL = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_CAP = 50;

    localparam logic [2:0] OP_NOP      = 3'd5;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

    typedef struct {
        logic [2:0]         opcode;
        logic signed [31:0] push_value;
        bit                 drain_first;
    } t_deque_cmd;

    typedef struct {
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [4:0]         element_count;
        logic               is_empty;
        logic               is_full;
        logic [1:0]         error_code;
    } t_deque_view;

    logic i_clk;
    logic i_rst_n;

    dq_op_if  cmd_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue #(.DEPTH(DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    t_deque_cmd  pending_cmds[$];
    t_deque_view expected_views[$];

    logic signed [31:0] mirror_slots[DEPTH];
    int mirror_head = 0;
    int mirror_tail = 0;
    int mirror_fill = 0;

    int planned_items = 0;
    int sent_count = 0;
    int got_count = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int overflow_hits = 0;
    int underflow_hits = 0;
    int full_hits = 0;
    int clear_hits = 0;
    int peak_fill = 0;

    int send_gap = 0;
    int recv_stall = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic t_deque_view apply_command(logic [2:0] opcode,
                                                  logic signed [31:0] value);
        t_deque_view view;
        view.error_code = dq_pkg::ERR_NONE;
        case (opcode)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
                if (mirror_fill >= DEPTH) begin
                    view.error_code = dq_pkg::ERR_OVERFLOW;
                    overflow_hits++;
                end else if (opcode == dq_pkg::OP_PUSH_FRONT) begin
                    mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
                    mirror_slots[mirror_head] = value;
                    mirror_fill++;
                end else begin
                    mirror_slots[mirror_tail] = value;
                    mirror_tail = (mirror_tail + 1) % DEPTH;
                    mirror_fill++;
                end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
                if (mirror_fill == 0) begin
                    view.error_code = dq_pkg::ERR_UNDERFLOW;
                    underflow_hits++;
                end else if (opcode == dq_pkg::OP_POP_FRONT) begin
                    mirror_head = (mirror_head + 1) % DEPTH;
                    mirror_fill--;
                end else begin
                    mirror_tail = (mirror_tail + DEPTH - 1) % DEPTH;
                    mirror_fill--;
                end
            end
            dq_pkg::OP_CLEAR: begin
                mirror_head = 0;
                mirror_tail = 0;
                mirror_fill = 0;
                clear_hits++;
            end
            default: ;
        endcase
        if (mirror_fill == 0) begin
            view.front_value = dq_pkg::EMPTY_VALUE;
            view.back_value  = dq_pkg::EMPTY_VALUE;
        end else begin
            view.front_value = mirror_slots[mirror_head];
            view.back_value  = mirror_slots[(mirror_tail + DEPTH - 1) % DEPTH];
        end
        view.element_count = mirror_fill[4:0];
        view.is_empty      = (mirror_fill == 0);
        view.is_full       = (mirror_fill == DEPTH);
        if (mirror_fill == DEPTH) full_hits++;
        if (mirror_fill > peak_fill) peak_fill = mirror_fill;
        return view;
    endfunction

    function automatic void plan(logic [2:0] opcode, logic signed [31:0] value,
                                 bit drain_first = 1'b0);
        t_deque_cmd item;
        item.opcode      = opcode;
        item.push_value  = value;
        item.drain_first = drain_first;
        pending_cmds.push_back(item);
        planned_items++;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] result %0d: %s", $time, got_count, what);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", field, got, want));
    endtask

    // The sender idles only in some windows and never near the end of the run.
    function automatic bit sender_may_idle();
        return (sent_count < planned_items - QUIET_TAIL) && ((sent_count / 60) % 3 != 1);
    endfunction

    function automatic bit receiver_may_idle();
        return (got_count < planned_items - QUIET_TAIL) && ((got_count / 50) % 3 != 2);
    endfunction

    always @(posedge i_clk) begin : cmd_driver
        t_deque_cmd next_cmd;
        bit fired;
        fired = 1'b0;
        if (!i_rst_n) begin
            cmd_ch.valid      <= 1'b0;
            cmd_ch.opcode     <= OP_NOP;
            cmd_ch.push_value <= '0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                expected_views.push_back(apply_command(cmd_ch.opcode, cmd_ch.push_value));
                sent_count++;
                fired = 1'b1;
            end
            if (!cmd_ch.valid || fired) begin
                if (fired && sender_may_idle() && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 15);
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end else if (pending_cmds.size() > 0 &&
                             !(pending_cmds[0].drain_first && expected_views.size() > 0)) begin
                    next_cmd = pending_cmds.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.opcode     <= next_cmd.opcode;
                    cmd_ch.push_value <= next_cmd.push_value;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_deque_view want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_views.size() == 0) begin
                    report_mismatch("result arrived with no command outstanding");
                end else begin
                    want = expected_views.pop_front();
                    check_field("front_value", rsp_ch.front_value, want.front_value);
                    check_field("back_value", rsp_ch.back_value, want.back_value);
                    check_field("element_count", 32'(rsp_ch.element_count),
                                32'(want.element_count));
                    check_field("is_empty", 32'(rsp_ch.is_empty), 32'(want.is_empty));
                    check_field("is_full", 32'(rsp_ch.is_full), 32'(want.is_full));
                    check_field("error_code", 32'(rsp_ch.error_code), 32'(want.error_code));
                    got_count++;
                end
            end
            if (recv_stall == 0 && receiver_may_idle() && $urandom_range(0, 5) == 0)
                recv_stall = $urandom_range(1, 15);
            if (recv_stall > 0) begin
                recv_stall--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [2:0]         opcode;
        logic signed [31:0] value;
        int                 bias;
        int                 roll;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        bias = 0;

        // Directed: underflow on both ends, extreme values, ignored opcodes,
        // a full queue that wraps the head pointer, overflow on both ends, clear.
        plan(dq_pkg::OP_POP_FRONT, $urandom);
        plan(dq_pkg::OP_POP_REAR, $urandom);
        plan(dq_pkg::OP_PUSH_FRONT, MOST_POSITIVE);
        plan(dq_pkg::OP_PUSH_REAR, MOST_NEGATIVE);
        plan(OP_NOP, $urandom);
        plan(OP_SPARE_LO, $urandom);
        plan(OP_SPARE_HI, $urandom);
        plan(dq_pkg::OP_POP_FRONT, $urandom);
        plan(dq_pkg::OP_POP_REAR, $urandom);
        for (int k = 0; k < DEPTH; k++) begin
            case (k)
                0: value = dq_pkg::EMPTY_VALUE;
                1: value = '0;
                2: value = MOST_NEGATIVE;
                3: value = MOST_POSITIVE;
                default: value = $urandom;
            endcase
            plan((k % 2 == 0) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_REAR, value);
        end
        plan(dq_pkg::OP_PUSH_FRONT, $urandom);
        plan(dq_pkg::OP_PUSH_REAR, $urandom);
        plan(dq_pkg::OP_CLEAR, $urandom);

        // Random: the mix of pushes and pops drifts so that the queue spends
        // time both near empty and at full.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 32 == 0) bias = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                opcode = dq_pkg::OP_CLEAR;
            end else if (roll < 7) begin
                opcode = 3'($urandom_range(OP_NOP, OP_SPARE_HI));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < ((bias == 0) ? 75 : (bias == 1) ? 25 : 50))
                    opcode = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_REAR
                                                  : dq_pkg::OP_PUSH_FRONT;
                else
                    opcode = $urandom_range(0, 1) ? dq_pkg::OP_POP_REAR
                                                  : dq_pkg::OP_POP_FRONT;
            end
            case ($urandom_range(0, 15))
                0: value = MOST_NEGATIVE;
                1: value = MOST_POSITIVE;
                2: value = dq_pkg::EMPTY_VALUE;
                3: value = '0;
                default: value = $urandom;
            endcase
            plan(opcode, value, n == 0 || n == RANDOM_ITEMS / 2);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (sent_count == planned_items && got_count == sent_count);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d deque commands and checked %0d results in %0d cycles.",
                 sent_count, got_count, cycle_count);
        $display("Overflows %0d, underflows %0d, full states %0d, clears %0d, peak fill %0d.",
                 overflow_hits, underflow_hits, full_hits, clear_hits, peak_fill);
        if (mismatch_count == 0 && expected_views.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out with %0d of %0d results received.", got_count, planned_items);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
